### hw/rtl/sfd_pkg.sv
// Shared constants, types and helpers of the sensor frame deframer.
package sfd_pkg;

    // Counter width; the result fields always show the low 16 bits.
    localparam int COUNT_WIDTH = 16;
    localparam int COUNT_OUT_WIDTH = 16;

    localparam int PAYLOAD_LEN = 11;
    localparam int INDEX_WIDTH = 4;

    localparam logic [7:0] MARK_A_FIRST = 8'h11;
    localparam logic [7:0] MARK_A_SECOND = 8'h88;
    localparam logic [7:0] MARK_B_FIRST = 8'h55;
    localparam logic [7:0] MARK_B_SECOND = 8'hAA;
    localparam logic [7:0] ERROR_CODE_MASK = 8'h0F;
    localparam logic [7:0] ANGLE_MODE_MASK = 8'h10;

    typedef enum logic [3:0] {
        HUNT_IDLE    = 4'b0001,
        HUNT_SAW_A   = 4'b0010,
        HUNT_SAW_B   = 4'b0100,
        HUNT_COLLECT = 4'b1000
    } hunt_state_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        logic                         checksum_ok;
        logic signed [31:0]           angle_increment;
        logic                         angle_mode;
        logic [7:0]                   param_id;
        logic [15:0]                  param_value;
        logic signed [15:0]           sample_interval;
        logic [7:0]                   sequence_number;
        logic [2:0]                   status_flags;
        logic [3:0]                   error_code;
        logic [COUNT_OUT_WIDTH-1:0]   frames_found;
        logic [COUNT_OUT_WIDTH-1:0]   checksum_fail_count;
        logic [COUNT_OUT_WIDTH-1:0]   marker_fail_count;
    } frame_result_t;

    // Handshake control between the byte register, the core and the result register.
    typedef struct packed {
        logic step;
        logic load;
    } stage_ctrl_t;

    // Low 16 bits of a counter, zero-extended when the counter is narrower.
    function automatic logic [COUNT_OUT_WIDTH-1:0] count_out(input count_t c);
        logic [COUNT_WIDTH+COUNT_OUT_WIDTH-1:0] wide;
        wide = {{COUNT_OUT_WIDTH{1'b0}}, c};
        return wide[COUNT_OUT_WIDTH-1:0];
    endfunction

endpackage

### hw/rtl/sfd_if.sv
// Channel interfaces of the sensor frame deframer: received bytes and decoded frames.
interface sfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_frame_if;
    logic               valid;
    logic               ready;
    logic               checksum_ok;
    logic signed [31:0] angle_increment;
    logic               angle_mode;
    logic [7:0]         param_id;
    logic [15:0]        param_value;
    logic signed [15:0] sample_interval;
    logic [7:0]         sequence_number;
    logic [2:0]         status_flags;
    logic [3:0]         error_code;
    logic [15:0]        frames_found;
    logic [15:0]        checksum_fail_count;
    logic [15:0]        marker_fail_count;

    modport source (
        output valid, input ready,
        output checksum_ok, output angle_increment, output angle_mode, output param_id,
        output param_value, output sample_interval, output sequence_number,
        output status_flags, output error_code, output frames_found,
        output checksum_fail_count, output marker_fail_count
    );
    modport sink (
        input valid, output ready,
        input checksum_ok, input angle_increment, input angle_mode, input param_id,
        input param_value, input sample_interval, input sequence_number,
        input status_flags, input error_code, input frames_found,
        input checksum_fail_count, input marker_fail_count
    );
endinterface

### hw/rtl/sfd_in_stage.sv
// Input register that holds one received byte until the core consumes it.
module sfd_in_stage
    import sfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sfd_byte_if.sink      rx,
    input  logic          advance,
    output logic          valid,
    output logic [7:0]    data
);

    logic       valid_reg;
    logic [7:0] data_reg;

    assign rx.ready = !valid_reg || advance;
    assign valid = valid_reg;
    assign data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            data_reg <= rx.rx_byte;
        end
    end

endmodule

### hw/rtl/sfd_frame_core.sv
// Marker hunt, payload collection, checksum check and frame counters.
module sfd_frame_core
    import sfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    data,
    output logic          emit,
    output frame_result_t result
);

    localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = INDEX_WIDTH'(PAYLOAD_LEN);
    localparam count_t COUNT_ONE = COUNT_WIDTH'(1);

    hunt_state_t             state_reg, state_next;
    logic [INDEX_WIDTH-1:0]  index_reg, index_next;
    logic [7:0]              sum_reg, sum_next;
    logic                    fail_flag_reg, fail_flag_next;
    count_t                  frames_reg, frames_next;
    count_t                  cs_fail_reg, cs_fail_next;
    count_t                  mk_fail_reg, mk_fail_next;
    logic [7:0]              payload_reg [PAYLOAD_LEN];
    logic                    write_en;
    logic                    sum_match;
    logic [7:0]              status;

    assign emit = (state_reg == HUNT_COLLECT) && (index_reg >= LAST_INDEX);
    assign sum_match = (sum_reg == data);

    always_comb
    begin
        state_next = state_reg;
        index_next = index_reg;
        sum_next = sum_reg;
        fail_flag_next = fail_flag_reg;
        frames_next = frames_reg;
        cs_fail_next = cs_fail_reg;
        mk_fail_next = mk_fail_reg;
        write_en = 1'b0;
        case (state_reg)
            HUNT_IDLE:
            begin
                if (data == MARK_A_FIRST)
                begin
                    state_next = HUNT_SAW_A;
                end
                else if (data == MARK_B_FIRST)
                begin
                    state_next = HUNT_SAW_B;
                end
                else if (!fail_flag_reg)
                begin
                    mk_fail_next = mk_fail_reg + COUNT_ONE;
                    fail_flag_next = 1'b1;
                end
            end
            HUNT_SAW_A, HUNT_SAW_B:
            begin
                if ((state_reg == HUNT_SAW_A && data == MARK_A_SECOND) ||
                    (state_reg == HUNT_SAW_B && data == MARK_B_SECOND))
                begin
                    state_next = HUNT_COLLECT;
                    index_next = '0;
                    sum_next = '0;
                    frames_next = frames_reg + COUNT_ONE;
                end
                else
                begin
                    // The bad second byte is consumed, not retried as a first byte.
                    state_next = HUNT_IDLE;
                    if (!fail_flag_reg)
                    begin
                        mk_fail_next = mk_fail_reg + COUNT_ONE;
                        fail_flag_next = 1'b1;
                    end
                end
            end
            HUNT_COLLECT:
            begin
                if (!emit)
                begin
                    write_en = 1'b1;
                    sum_next = sum_reg + data;
                    index_next = index_reg + INDEX_WIDTH'(1);
                end
                else
                begin
                    if (!sum_match)
                    begin
                        cs_fail_next = cs_fail_reg + COUNT_ONE;
                    end
                    state_next = HUNT_IDLE;
                    index_next = '0;
                    sum_next = '0;
                    fail_flag_next = 1'b0;
                end
            end
            default:
            begin
                state_next = HUNT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HUNT_IDLE;
            index_reg <= '0;
            sum_reg <= '0;
            fail_flag_reg <= 1'b0;
            frames_reg <= '0;
            cs_fail_reg <= '0;
            mk_fail_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            index_reg <= index_next;
            sum_reg <= sum_next;
            fail_flag_reg <= fail_flag_next;
            frames_reg <= frames_next;
            cs_fail_reg <= cs_fail_next;
            mk_fail_reg <= mk_fail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && write_en)
        begin
            payload_reg[index_reg] <= data;
        end
    end

    assign status = payload_reg[10];

    always_comb
    begin
        result.checksum_ok = sum_match;
        result.angle_increment = {payload_reg[3], payload_reg[2], payload_reg[1],
                                  payload_reg[0]};
        result.angle_mode = |(status & ANGLE_MODE_MASK);
        result.param_id = payload_reg[4];
        result.param_value = {payload_reg[6], payload_reg[5]};
        result.sample_interval = {payload_reg[8], payload_reg[7]};
        result.sequence_number = payload_reg[9];
        result.status_flags = status[7:5];
        result.error_code = 4'(status & ERROR_CODE_MASK);
        result.frames_found = count_out(frames_next);
        result.checksum_fail_count = count_out(cs_fail_next);
        result.marker_fail_count = count_out(mk_fail_next);
    end

endmodule

### hw/rtl/sfd_out_stage.sv
// Result register that holds a decoded frame until the sink takes it.
module sfd_out_stage
    import sfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  frame_result_t result,
    output logic          free,
    sfd_frame_if.source   frame
);

    logic          valid_reg;
    frame_result_t result_reg;

    assign free = !valid_reg || frame.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (frame.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign frame.valid = valid_reg;
    assign frame.checksum_ok = result_reg.checksum_ok;
    assign frame.angle_increment = result_reg.angle_increment;
    assign frame.angle_mode = result_reg.angle_mode;
    assign frame.param_id = result_reg.param_id;
    assign frame.param_value = result_reg.param_value;
    assign frame.sample_interval = result_reg.sample_interval;
    assign frame.sequence_number = result_reg.sequence_number;
    assign frame.status_flags = result_reg.status_flags;
    assign frame.error_code = result_reg.error_code;
    assign frame.frames_found = result_reg.frames_found;
    assign frame.checksum_fail_count = result_reg.checksum_fail_count;
    assign frame.marker_fail_count = result_reg.marker_fail_count;

endmodule

### hw/rtl/sensor_frame_deframer_unit.sv
// Top level of the sensor frame deframer.
//
//   Channel  Direction  Beat
//   rx       in         one received byte from the serial link
//   frame    out        one decoded frame with checksum flag and counters
//
// Each byte passes the input register and then the hunt/collect logic, so one byte
// is taken every cycle unless a checksum byte waits on a full result register.
// A frame result is loaded into the result register at the edge that consumes its
// checksum byte from the input register.
// Reset clears the hunt state, sums and counters; the payload store is not reset.
// Only a checksum byte waits on a full result register; other bytes keep flowing.
module sensor_frame_deframer_unit
    import sfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sfd_byte_if.sink    rx,
    sfd_frame_if.source frame
);

    logic          byte_valid;
    logic [7:0]    byte_data;
    logic          emit;
    logic          out_free;
    logic          advance;
    frame_result_t result;
    stage_ctrl_t   ctrl;

    // A byte that makes no result never waits for the result register.
    assign advance = !emit || out_free;
    assign ctrl.step = byte_valid && advance;
    assign ctrl.load = byte_valid && advance && emit;

    sfd_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .advance (advance),
        .valid   (byte_valid),
        .data    (byte_data)
    );

    sfd_frame_core u_frame_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (ctrl.step),
        .data   (byte_data),
        .emit   (emit),
        .result (result)
    );

    sfd_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (ctrl.load),
        .result (result),
        .free   (out_free),
        .frame  (frame)
    );

endmodule
